// ===== hw/rtl/sqlm_pkg.sv =====
// sqlm_pkg: shared constants, types and helpers for the sql comment and literal masker
// no dependencies; compiled first

package sqlm_pkg;

   localparam int TAG_MAX_DEF    = 14;
   localparam int DEPTH_BITS_DEF = 16;

   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_QUOTE   = 8'h27;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   // per-step status that travels with the result bytes
   typedef struct packed {
      logic tag_too_long;
      logic text_last;
   } sqlm_step_type;

   // letters, digits and underscore
   function automatic logic is_tag_char(input logic [7:0] ch);
      logic hit;
      hit = (ch inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]}) || (ch == CH_UNDER);
      return hit;
   endfunction

endpackage

// ===== hw/rtl/sqlm_if.sv =====
// sqlm_req_if / sqlm_rsp_if: valid-ready channels for the masker
// no dependencies

interface sqlm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface sqlm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic       tag_too_long;

   modport source (output valid, output out_byte, output out_last, output tag_too_long,
                   input ready);
   modport sink (input valid, input out_byte, input out_last, input tag_too_long,
                 output ready);
endinterface

// ===== hw/rtl/sqlm_lexer.sv =====
// sqlm_lexer: lexer state and the single-pass step logic that builds one transaction's results
// depends on sqlm_pkg

module sqlm_lexer #(
   parameter int TAG_MAX    = sqlm_pkg::TAG_MAX_DEF,
   parameter int DEPTH_BITS = sqlm_pkg::DEPTH_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [7:0]                    in_byte,
   input  logic                          in_last,
   output logic [7:0]                    res_bytes [TAG_MAX+2],
   output logic [$clog2(TAG_MAX+3)-1:0]  res_cnt,
   output sqlm_pkg::sqlm_step_type       res_info
);
   import sqlm_pkg::*;

   localparam int HD  = TAG_MAX + 1;
   localparam int TD  = TAG_MAX + 2;
   localparam int HCW = $clog2(HD + 1);
   localparam int TLW = $clog2(TD + 1);

   typedef enum logic [2:0] {
      M_NORMAL, M_LINE, M_BLOCK, M_QUOTE, M_QUOTE_END, M_TAG, M_BODY
   } mode_type;

   typedef enum logic [1:0] {P_NONE, P_DASH, P_SLASH, P_STAR} pend_type;

   mode_type              mode_ff, mode_in;
   pend_type              pend_ff, pend_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [HCW-1:0]        hcnt_ff, hcnt_in;
   logic [TLW-1:0]        tlen_ff, tlen_in;
   logic [TLW-1:0]        bcnt_ff, bcnt_in;
   logic [7:0]            held_l_ff [HD];
   logic [7:0]            held_r_ff [HD];
   logic [7:0]            tag_ff [TD];
   logic [7:0]            win_ff [TD];

   logic [7:0]     c;
   logic [7:0]     c_blank;
   logic           hold_start, hold_append, tag_load, win_shift, use_plain;
   logic [HCW-1:0] pc;
   logic           pblank;
   logic [1:0][7:0] tail;
   logic [1:0]     tc;
   logic           flag;

   logic           pl_emit, pl_start;
   logic [7:0]     pl_val;
   mode_type       pl_mode;
   pend_type       pl_pend;

   logic [7:0]     win_nx [TD];
   logic [TLW-1:0] bcnt_nx;
   logic           win_match;
   logic [7:0]     pre_src [TD];
   logic [TLW-1:0] pcw;

   assign c       = in_byte;
   assign c_blank = (c == CH_NEWLINE) ? CH_NEWLINE : CH_SPACE;

   // what a byte of plain text does
   always_comb begin
      pl_emit  = 1'b0;
      pl_val   = c;
      pl_start = 1'b0;
      pl_mode  = M_NORMAL;
      pl_pend  = P_NONE;
      if (c == CH_DASH) begin
         pl_pend = P_DASH;
      end else if (c == CH_SLASH) begin
         pl_pend = P_SLASH;
      end else if (c == CH_QUOTE) begin
         pl_emit = 1'b1;
         pl_val  = CH_SPACE;
         pl_mode = M_QUOTE;
      end else if (c == CH_DOLLAR) begin
         pl_start = 1'b1;
         pl_mode  = M_TAG;
      end else begin
         pl_emit = 1'b1;
      end
   end

   // closing tag search over the right-aligned tag and body window
   always_comb begin
      win_nx[TD-1] = c;
      for (int j = 0; j < TD - 1; j++) begin
         win_nx[j] = win_ff[j+1];
      end
      bcnt_nx   = (bcnt_ff < tlen_ff) ? bcnt_ff + 1'b1 : bcnt_ff;
      win_match = (tlen_ff != '0) && (bcnt_nx == tlen_ff);
      for (int j = 0; j < TD; j++) begin
         if ((tlen_ff >= TLW'(TD - j)) && (win_nx[j] != tag_ff[j])) begin
            win_match = 1'b0;
         end
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      pend_in     = pend_ff;
      depth_in    = depth_ff;
      hcnt_in     = hcnt_ff;
      tlen_in     = tlen_ff;
      bcnt_in     = bcnt_ff;
      hold_start  = 1'b0;
      hold_append = 1'b0;
      tag_load    = 1'b0;
      win_shift   = 1'b0;
      use_plain   = 1'b0;
      pc          = '0;
      pblank      = 1'b0;
      tail        = '0;
      tc          = '0;
      flag        = 1'b0;

      case (mode_ff)
         M_NORMAL: begin
            if (pend_ff == P_DASH && c == CH_DASH) begin
               tail    = {CH_SPACE, CH_SPACE};
               tc      = 2'd2;
               pend_in = P_NONE;
               mode_in = M_LINE;
            end else if (pend_ff == P_SLASH && c == CH_STAR) begin
               tail     = {CH_SPACE, CH_SPACE};
               tc       = 2'd2;
               pend_in  = P_NONE;
               depth_in = DEPTH_BITS'(1);
               mode_in  = M_BLOCK;
            end else begin
               if (pend_ff == P_DASH) begin
                  tail[0] = CH_DASH;
                  tc      = 2'd1;
               end else if (pend_ff != P_NONE) begin
                  tail[0] = CH_SLASH;
                  tc      = 2'd1;
               end
               use_plain = 1'b1;
            end
         end
         M_LINE: begin
            tail[0] = c_blank;
            tc      = 2'd1;
            if (c == CH_NEWLINE) begin
               mode_in = M_NORMAL;
            end
         end
         M_BLOCK: begin
            tail[0] = c_blank;
            tc      = 2'd1;
            if (pend_ff == P_SLASH && c == CH_STAR) begin
               if (depth_ff != '1) begin
                  depth_in = depth_ff + 1'b1;
               end
               pend_in = P_NONE;
            end else if (pend_ff == P_STAR && c == CH_SLASH) begin
               if (depth_ff != '0) begin
                  depth_in = depth_ff - 1'b1;
               end
               pend_in = P_NONE;
               if (depth_in == '0) begin
                  mode_in = M_NORMAL;
               end
            end else begin
               pend_in = (c == CH_SLASH) ? P_SLASH : (c == CH_STAR) ? P_STAR : P_NONE;
            end
         end
         M_QUOTE: begin
            tail[0] = c_blank;
            tc      = 2'd1;
            if (c == CH_QUOTE) begin
               mode_in = M_QUOTE_END;
            end
         end
         M_QUOTE_END: begin
            if (c == CH_QUOTE) begin
               tail[0] = CH_SPACE;
               tc      = 2'd1;
               mode_in = M_QUOTE;
            end else begin
               use_plain = 1'b1;
            end
         end
         M_TAG: begin
            if (c == CH_DOLLAR) begin
               // tag confirmed: blank the opener and start the body
               pc       = hcnt_ff;
               pblank   = 1'b1;
               tail[0]  = CH_SPACE;
               tc       = 2'd1;
               tag_load = 1'b1;
               tlen_in  = TLW'(hcnt_ff) + TLW'(1);
               hcnt_in  = '0;
               bcnt_in  = '0;
               mode_in  = M_BODY;
            end else if (is_tag_char(c)) begin
               if (hcnt_ff < HCW'(HD)) begin
                  hold_append = 1'b1;
                  hcnt_in     = hcnt_ff + 1'b1;
               end else begin
                  // overlong tag goes out as plain text
                  pc      = hcnt_ff;
                  tail[0] = c;
                  tc      = 2'd1;
                  flag    = 1'b1;
                  hcnt_in = '0;
                  mode_in = M_NORMAL;
               end
            end else begin
               pc        = hcnt_ff;
               hcnt_in   = '0;
               use_plain = 1'b1;
            end
         end
         M_BODY: begin
            tail[0]   = c_blank;
            tc        = 2'd1;
            win_shift = 1'b1;
            bcnt_in   = bcnt_nx;
            if (win_match) begin
               mode_in = M_NORMAL;
               bcnt_in = '0;
            end
         end
         default: begin
            use_plain = 1'b1;
         end
      endcase

      if (use_plain) begin
         mode_in = pl_mode;
         pend_in = pl_pend;
         if (pl_emit) begin
            tail[tc[0]] = pl_val;
            tc          = tc + 2'd1;
         end
         if (pl_start) begin
            hold_start = 1'b1;
            hcnt_in    = HCW'(1);
         end
      end

      // end of text: release whatever is held, then back to reset values
      if (in_last) begin
         if (mode_in == M_NORMAL && pend_in == P_DASH) begin
            tail[tc[0]] = CH_DASH;
            tc          = tc + 2'd1;
         end else if (mode_in == M_NORMAL && pend_in == P_SLASH) begin
            tail[tc[0]] = CH_SLASH;
            tc          = tc + 2'd1;
         end
         if (mode_in == M_TAG) begin
            if (hold_append) begin
               pc          = hcnt_ff;
               tail[tc[0]] = c;
            end else begin
               tail[tc[0]] = CH_DOLLAR;
            end
            tc = tc + 2'd1;
         end
         mode_in  = M_NORMAL;
         pend_in  = P_NONE;
         depth_in = '0;
         hcnt_in  = '0;
         tlen_in  = '0;
         bcnt_in  = '0;
      end
   end

   // held bytes (or blanks) first, then the tail bytes
   always_comb begin
      for (int j = 0; j < HD; j++) begin
         pre_src[j] = pblank ? CH_SPACE : held_l_ff[j];
      end
      pre_src[TD-1] = CH_SPACE;
      pcw = TLW'(pc);
      for (int j = 0; j < TD; j++) begin
         if (TLW'(j) < pcw) begin
            res_bytes[j] = pre_src[j];
         end else if (TLW'(j) == pcw) begin
            res_bytes[j] = tail[0];
         end else begin
            res_bytes[j] = tail[1];
         end
      end
      res_cnt               = pcw + TLW'(tc);
      res_info.tag_too_long = flag;
      res_info.text_last    = in_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_NORMAL;
         pend_ff  <= P_NONE;
         depth_ff <= '0;
         hcnt_ff  <= '0;
         tlen_ff  <= '0;
         bcnt_ff  <= '0;
      end else if (step_en) begin
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         depth_ff <= depth_in;
         hcnt_ff  <= hcnt_in;
         tlen_ff  <= tlen_in;
         bcnt_ff  <= bcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         for (int j = 0; j < HD; j++) begin
            if ((hold_start && j == 0) || (hold_append && hcnt_ff == HCW'(j))) begin
               held_l_ff[j] <= c;
            end
         end
         // right-aligned copy of the held tag, ready to become the closing pattern
         if (hold_start || hold_append) begin
            for (int j = 0; j < HD - 1; j++) begin
               held_r_ff[j] <= held_r_ff[j+1];
            end
            held_r_ff[HD-1] <= c;
         end
         if (tag_load) begin
            for (int j = 0; j < HD; j++) begin
               tag_ff[j] <= held_r_ff[j];
            end
            tag_ff[TD-1] <= CH_DOLLAR;
         end
         if (win_shift) begin
            for (int j = 0; j < TD; j++) begin
               win_ff[j] <= win_nx[j];
            end
         end
      end
   end

   a_held_in_tag: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == M_TAG) == (hcnt_ff != '0))
      else $error("held tag count out of step with tag mode");

   a_depth_in_block: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == M_BLOCK) == (depth_ff != '0))
      else $error("comment depth out of step with block mode");

   a_body_count: assert property (@(posedge clock) disable iff (reset)
      bcnt_ff <= tlen_ff)
      else $error("body count beyond tag length");

endmodule

// ===== hw/rtl/sql_comment_and_literal_masker.sv =====
// sql_comment_and_literal_masker: input register, lexer step and result drain buffer
// depends on sqlm_pkg, sqlm_if (sqlm_req_if, sqlm_rsp_if) and sqlm_lexer
//
//   port    direction  payload                                  transaction when
//   req     sink       in_byte[7:0], in_last                    req.valid && req.ready
//   rsp     source     out_byte[7:0], out_last, tag_too_long    rsp.valid && rsp.ready
//
// one result leaves per cycle while rsp.ready is high; an input byte gives 0 to TAG_MAX+2 results,
// held in the result buffer till taken, so plain text runs at one byte per cycle while rsp is ready
// a req byte passes through the input register and then the result buffer before it leaves on rsp
// a held input byte steps the lexer when the buffer is empty or its last entry is taken in that cycle
// reset is synchronous and active high; it clears the lexer state and both valid flags
// a stalled rsp fills the input register, after which req.ready drops

module sql_comment_and_literal_masker #(
   parameter int TAG_MAX    = sqlm_pkg::TAG_MAX_DEF,
   parameter int DEPTH_BITS = sqlm_pkg::DEPTH_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   sqlm_req_if.sink   req,
   sqlm_rsp_if.source rsp
);
   import sqlm_pkg::*;

   localparam int TD = TAG_MAX + 2;
   localparam int CW = $clog2(TD + 1);

   logic          in_valid_ff;
   logic [7:0]    in_byte_ff;
   logic          in_last_ff;

   logic [7:0]    res_ff [TD];
   logic [CW-1:0] cnt_ff;
   sqlm_step_type info_ff;

   logic [7:0]    lex_bytes [TD];
   logic [CW-1:0] lex_cnt;
   sqlm_step_type lex_info;

   logic          req_take;
   logic          rsp_take;
   logic          step;

   assign req_take  = req.valid && req.ready;
   assign rsp_take  = rsp.valid && rsp.ready;
   assign step      = in_valid_ff && ((cnt_ff == '0) || ((cnt_ff == CW'(1)) && rsp_take));
   assign req.ready = !in_valid_ff || step;

   assign rsp.valid        = (cnt_ff != '0);
   assign rsp.out_byte     = res_ff[0];
   assign rsp.out_last     = info_ff.text_last && (cnt_ff == CW'(1));
   assign rsp.tag_too_long = info_ff.tag_too_long;

   sqlm_lexer #(
      .TAG_MAX    (TAG_MAX),
      .DEPTH_BITS (DEPTH_BITS)
   ) u_lexer (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step),
      .in_byte   (in_byte_ff),
      .in_last   (in_last_ff),
      .res_bytes (lex_bytes),
      .res_cnt   (lex_cnt),
      .res_info  (lex_info)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req.in_byte;
         in_last_ff <= req.in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (step) begin
         cnt_ff <= lex_cnt;
      end else if (rsp_take) begin
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   // results leave from the head; the rest move up one place per transaction
   always_ff @(posedge clock) begin
      if (step) begin
         for (int j = 0; j < TD; j++) begin
            res_ff[j] <= lex_bytes[j];
         end
         info_ff <= lex_info;
      end else if (rsp_take) begin
         for (int j = 0; j < TD - 1; j++) begin
            res_ff[j] <= res_ff[j+1];
         end
      end
   end

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step) |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff)))
      else $error("input register lost a waiting byte");

   a_drain_by_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !step) |=> (cnt_ff == $past(cnt_ff) - CW'(1)))
      else $error("result buffer did not drain by one");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      step |=> (cnt_ff <= CW'(TD)))
      else $error("result count beyond buffer depth");

endmodule
